FILE: rtl/lds_pkg.sv
package lds_pkg;

   // field widths fixed at the ports
   localparam int SEC_W     = 48;
   localparam int LEN_W     = 16;
   localparam int CNT_OUT_W = 6;

   // defaults for the top level parameters
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int LBA_BITS_DEF    = 48;

   typedef enum logic {
      OP_ADD      = 1'b0,
      OP_DISPATCH = 1'b1
   } lds_op_type;

   typedef enum logic [1:0] {
      ST_ADDED      = 2'd0,
      ST_FULL       = 2'd1,
      ST_DISPATCHED = 2'd2,
      ST_EMPTY      = 2'd3
   } lds_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FREE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_FIX,
      S_FIX_DRAIN
   } lds_state_type;

   typedef struct packed {
      lds_op_type        opcode;
      logic [SEC_W-1:0]  req_sector;
      logic [LEN_W-1:0]  req_length;
   } lds_req_type;

   typedef struct packed {
      lds_status_type        status;
      logic [SEC_W-1:0]      out_sector;
      logic [LEN_W-1:0]      out_length;
      logic                  sweep_up_now;
      logic [CNT_OUT_W-1:0]  pending_count;
   } lds_rsp_type;

   // control from the sequencer to the picker
   typedef struct packed {
      logic clear;
      logic sample;
      logic sweep_up;
      logic lone;
   } lds_pick_ctl_type;

   // picker verdict
   typedef struct packed {
      logic found;
      logic flip;
   } lds_pick_stat_type;

endpackage

FILE: rtl/lds_ram.sv
module lds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lds_pick.sv
module lds_pick
   import lds_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int LBA_BITS    = LBA_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lds_pick_ctl_type               ctl,
   input  logic [LBA_BITS-1:0]            head,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] e_idx,
   input  logic [LBA_BITS-1:0]            e_sector,
   input  logic [LEN_W-1:0]               e_length,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] e_age,
   output lds_pick_stat_type              stat,
   output logic [$clog2(QUEUE_DEPTH)-1:0] sel_idx,
   output logic [LBA_BITS-1:0]            sel_sector,
   output logic [LEN_W-1:0]               sel_length,
   output logic [$clog2(QUEUE_DEPTH)-1:0] sel_age
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   // best ahead of the head (a) and best extreme for the reversed sweep (b)
   logic                a_fnd_ff, a_fnd_in;
   logic [IDX_W-1:0]    a_idx_ff;
   logic [LBA_BITS-1:0] a_sec_ff;
   logic [LEN_W-1:0]    a_len_ff;
   logic [IDX_W-1:0]    a_age_ff;
   logic                b_fnd_ff, b_fnd_in;
   logic [IDX_W-1:0]    b_idx_ff;
   logic [LBA_BITS-1:0] b_sec_ff;
   logic [LEN_W-1:0]    b_len_ff;
   logic [IDX_W-1:0]    b_age_ff;

   logic a_cand, a_beat, a_take;
   logic b_beat, b_take;

   // compare the incoming entry against both running bests
   always_comb begin
      a_cand = ctl.sweep_up ? (e_sector > head) : (e_sector < head);
      a_beat = ctl.sweep_up ? (e_sector < a_sec_ff) : (e_sector > a_sec_ff);
      b_beat = ctl.sweep_up ? (e_sector > b_sec_ff) : (e_sector < b_sec_ff);
      a_take = ctl.sample && a_cand &&
               (!a_fnd_ff || ((e_sector == a_sec_ff) ? (e_age < a_age_ff) : a_beat));
      b_take = ctl.sample &&
               (!b_fnd_ff || ((e_sector == b_sec_ff) ? (e_age < b_age_ff) : b_beat));
      a_fnd_in = ctl.clear ? 1'b0 : (a_fnd_ff || a_take);
      b_fnd_in = ctl.clear ? 1'b0 : (b_fnd_ff || b_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_fnd_ff <= 1'b0;
         b_fnd_ff <= 1'b0;
      end else begin
         a_fnd_ff <= a_fnd_in;
         b_fnd_ff <= b_fnd_in;
      end
   end

   // payload of the running bests
   always_ff @(posedge clock) begin
      if (a_take) begin
         a_idx_ff <= e_idx;
         a_sec_ff <= e_sector;
         a_len_ff <= e_length;
         a_age_ff <= e_age;
      end
      if (b_take) begin
         b_idx_ff <= e_idx;
         b_sec_ff <= e_sector;
         b_len_ff <= e_length;
         b_age_ff <= e_age;
      end
   end

   // lone request goes straight out, otherwise ahead first, then reverse
   always_comb begin
      if (ctl.lone || !a_fnd_ff) begin
         stat.found = b_fnd_ff;
         stat.flip  = b_fnd_ff && !ctl.lone;
         sel_idx    = b_idx_ff;
         sel_sector = b_sec_ff;
         sel_length = b_len_ff;
         sel_age    = b_age_ff;
      end else begin
         stat.found = 1'b1;
         stat.flip  = 1'b0;
         sel_idx    = a_idx_ff;
         sel_sector = a_sec_ff;
         sel_length = a_len_ff;
         sel_age    = a_age_ff;
      end
   end

endmodule

FILE: rtl/look_disk_request_scheduler_unit.sv
// LOOK disk request scheduler
// Input channel: req_item carries opcode, req_sector and req_length. An item is
// taken at a rising edge with start high and busy low; busy stays high until
// the item is fully worked off.
// Result channel: rsp_item is valid for exactly one cycle while rsp_strobe is
// high. The receiver cannot hold results off, so it must take every strobe.
// Every item gives exactly one result.
// A full-queue add or an empty dispatch answers in the cycle after accept.
// An add walks the valid bits for the first free slot, one slot a cycle, and
// answers once it finds one.
// A dispatch reads every slot of the request memory once (one read port, one
// slot a cycle) and answers with the chosen request; the block then stays
// busy while a second pass over the memory renumbers the queue order, so the
// next item is taken only once that pass is done.
// Reset empties the queue, parks the head at sector zero and sets the sweep
// upward; memory contents are not cleared, slots are only used once written.
module look_disk_request_scheduler_unit
   import lds_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int LBA_BITS    = LBA_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  lds_req_type req_item,
   output logic        rsp_strobe,
   output lds_rsp_type rsp_item
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int AGE_W   = IDX_W;
   localparam int ENTRY_W = LBA_BITS + LEN_W + AGE_W;

   lds_state_type          state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       held_ff, held_in;
   logic [LBA_BITS-1:0]    head_ff, head_in;
   logic                   sweep_up_ff, sweep_up_in;
   lds_req_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]       sel_idx_ff, sel_idx_in;
   logic [AGE_W-1:0]       sel_age_ff, sel_age_in;
   lds_rsp_type            rsp_ff, rsp_in;
   logic                   strobe_ff, strobe_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [ENTRY_W-1:0]     ram_wdata;
   logic [ENTRY_W-1:0]     ram_rdata;
   logic [LBA_BITS-1:0]    rd_sector;
   logic [LEN_W-1:0]       rd_length;
   logic [AGE_W-1:0]       rd_age;

   lds_pick_ctl_type       pick_ctl;
   lds_pick_stat_type      pick_stat;
   logic [IDX_W-1:0]       pick_idx;
   logic [LBA_BITS-1:0]    pick_sector;
   logic [LEN_W-1:0]       pick_length;
   logic [AGE_W-1:0]       pick_age;

   function automatic lds_rsp_type pack_rsp(lds_status_type st,
                                            logic [LBA_BITS-1:0] sec,
                                            logic [LEN_W-1:0] len,
                                            logic up,
                                            logic [CNT_W-1:0] cnt);
      lds_rsp_type r;
      r.status        = st;
      r.out_sector    = SEC_W'(sec);
      r.out_length    = len;
      r.sweep_up_now  = up;
      r.pending_count = CNT_OUT_W'(cnt);
      return r;
   endfunction

   // request memory: sector, length and queue order of each slot
   lds_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign rd_sector = ram_rdata[ENTRY_W-1 -: LBA_BITS];
   assign rd_length = ram_rdata[AGE_W+LEN_W-1 -: LEN_W];
   assign rd_age    = ram_rdata[AGE_W-1:0];

   // running best search over the scanned slots
   lds_pick #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .LBA_BITS    (LBA_BITS)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pick_ctl),
      .head       (head_ff),
      .e_idx      (rd_idx_ff),
      .e_sector   (rd_sector),
      .e_length   (rd_length),
      .e_age      (rd_age),
      .stat       (pick_stat),
      .sel_idx    (pick_idx),
      .sel_sector (pick_sector),
      .sel_length (pick_length),
      .sel_age    (pick_age)
   );

   // sequencer: next state and datapath control
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = idx_ff;
      valid_in    = valid_ff;
      held_in     = held_ff;
      head_in     = head_ff;
      sweep_up_in = sweep_up_ff;
      cmd_in      = cmd_ff;
      sel_idx_in  = sel_idx_ff;
      sel_age_in  = sel_age_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = rd_idx_ff;
      ram_wdata   = {rd_sector, rd_length, rd_age - AGE_W'(1)};

      pick_ctl.clear    = 1'b0;
      pick_ctl.sample   = rd_vld_ff && valid_ff[rd_idx_ff] &&
                          (state_ff == S_SCAN || state_ff == S_DRAIN);
      pick_ctl.sweep_up = sweep_up_ff;
      pick_ctl.lone     = (held_ff == CNT_W'(1));

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_item;
               idx_in = '0;
               if (req_item.opcode == OP_ADD) begin
                  if (held_ff == CNT_W'(QUEUE_DEPTH)) begin
                     rsp_in    = pack_rsp(ST_FULL, '0, '0, sweep_up_ff, held_ff);
                     strobe_in = 1'b1;
                  end else begin
                     state_in = S_FREE;
                  end
               end else begin
                  if (held_ff == '0) begin
                     rsp_in    = pack_rsp(ST_EMPTY, '0, '0, sweep_up_ff, held_ff);
                     strobe_in = 1'b1;
                  end else begin
                     pick_ctl.clear = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
            end
         end
         // first free slot takes the new request
         S_FREE: begin
            if (!valid_ff[idx_ff]) begin
               ram_we           = 1'b1;
               ram_waddr        = idx_ff;
               ram_wdata        = {LBA_BITS'(cmd_ff.req_sector), cmd_ff.req_length,
                                   AGE_W'(held_ff)};
               valid_in[idx_ff] = 1'b1;
               held_in          = held_ff + CNT_W'(1);
               rsp_in           = pack_rsp(ST_ADDED, '0, '0, sweep_up_ff, held_in);
               strobe_in        = 1'b1;
               state_in         = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         // read every slot into the picker
         S_SCAN: begin
            rd_vld_in = 1'b1;
            if (idx_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         // take the chosen request out of the queue
         S_DECIDE: begin
            if (pick_stat.found) begin
               valid_in[pick_idx] = 1'b0;
               held_in            = held_ff - CNT_W'(1);
               head_in            = pick_sector + LBA_BITS'(pick_length);
               sweep_up_in        = pick_stat.flip ? !sweep_up_ff : sweep_up_ff;
               sel_idx_in         = pick_idx;
               sel_age_in         = pick_age;
               rsp_in             = pack_rsp(ST_DISPATCHED, pick_sector, pick_length,
                                             sweep_up_in, held_in);
               strobe_in          = 1'b1;
               idx_in             = '0;
               state_in           = S_FIX;
            end else begin
               rsp_in    = pack_rsp(ST_EMPTY, '0, '0, sweep_up_ff, held_ff);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         // renumber queue order: later requests move up by one
         S_FIX: begin
            rd_vld_in = 1'b1;
            ram_we    = rd_vld_ff && valid_ff[rd_idx_ff] && (rd_age > sel_age_ff);
            if (idx_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
               state_in = S_FIX_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_FIX_DRAIN: begin
            ram_we   = rd_vld_ff && valid_ff[rd_idx_ff] && (rd_age > sel_age_ff);
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_vld_ff   <= 1'b0;
         valid_ff    <= '0;
         held_ff     <= '0;
         head_ff     <= '0;
         sweep_up_ff <= 1'b1;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= rd_vld_in;
         valid_ff    <= valid_in;
         held_ff     <= held_in;
         head_ff     <= head_in;
         sweep_up_ff <= sweep_up_in;
         strobe_ff   <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rd_idx_ff  <= rd_idx_in;
      cmd_ff     <= cmd_in;
      sel_idx_ff <= sel_idx_in;
      sel_age_ff <= sel_age_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // valid bits and held count agree whenever no item is at work
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_ff) == held_ff))
      else $error("valid bits and held count disagree");

   a_held_max: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("held count beyond queue depth");

   // the removed slot must not be renumbered
   a_fix_removed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIX || state_ff == S_FIX_DRAIN) |-> !valid_ff[sel_idx_ff])
      else $error("dispatched slot still valid during renumbering");

   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_ADDED) |->
         (held_ff == $past(held_ff) + CNT_W'(1)))
      else $error("add did not raise the held count");

   a_disp_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_DISPATCHED) |->
         (held_ff == $past(held_ff) - CNT_W'(1)))
      else $error("dispatch did not lower the held count");

endmodule
